@@ rtl/core/gfcs_pkg.sv @@
`default_nettype none

package gfcs_pkg;

    // Field widths of the item formats
    localparam int SAT_WIDTH   = 7;
    localparam int VALUE_WIDTH = 48;
    localparam int TRACK_WIDTH = 16;
    localparam int CODE_WIDTH  = 3;

    localparam int NUM_SATS_DEFAULT = 128;

    // Result queue depth; also the limit on items in flight
    localparam int OUT_FIFO_DEPTH = 4;

    // Configuration port
    localparam int CFG_ADDR_WIDTH    = 4;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int JUMP_LIMIT_WIDTH  = 20;
    localparam int DIFF_LIMIT_WIDTH  = 20;
    localparam int STEP_LIMIT_WIDTH  = 24;
    localparam int PRIOR_LIMIT_WIDTH = 20;

    localparam logic [JUMP_LIMIT_WIDTH-1:0]  JUMP_LIMIT_RESET  = 20'd200;
    localparam logic [DIFF_LIMIT_WIDTH-1:0]  DIFF_LIMIT_RESET  = 20'd500;
    localparam logic [STEP_LIMIT_WIDTH-1:0]  STEP_LIMIT_RESET  = 24'd50000;
    localparam logic [PRIOR_LIMIT_WIDTH-1:0] PRIOR_LIMIT_RESET = 20'd250;

    typedef enum logic [1:0] {
        REG_JUMP_LIMIT  = 2'd0,
        REG_DIFF_LIMIT  = 2'd1,
        REG_STEP_LIMIT  = 2'd2,
        REG_PRIOR_LIMIT = 2'd3
    } t_reg_idx;

    typedef enum logic [CODE_WIDTH-1:0] {
        CASE_MISSING      = 3'd0,
        CASE_FIRST        = 3'd1,
        CASE_SECOND_OK    = 3'd2,
        CASE_SECOND_SLIP  = 3'd3,
        CASE_SMOOTH       = 3'd4,
        CASE_STEP_SLIP    = 3'd5,
        CASE_PRIOR_SLIP   = 3'd6,
        CASE_CURRENT_SLIP = 3'd7
    } t_case_code;

    typedef enum logic [1:0] {
        EPOCH_FIRST  = 2'd0,
        EPOCH_SECOND = 2'd1,
        EPOCH_LATER  = 2'd2
    } t_epoch;

    typedef struct packed {
        logic [SAT_WIDTH-1:0]          sat_index;
        logic                          pair_select;
        logic signed [VALUE_WIDTH-1:0] gf_value;
    } t_in_item;

    typedef struct packed {
        logic [SAT_WIDTH-1:0]   sat_echo;
        logic                   pair_echo;
        logic                   slip;
        logic [CODE_WIDTH-1:0]  case_code;
        logic [TRACK_WIDTH-1:0] track_count;
    } t_out_item;

    typedef struct packed {
        logic [JUMP_LIMIT_WIDTH-1:0]  jump;
        logic [DIFF_LIMIT_WIDTH-1:0]  diff;
        logic [STEP_LIMIT_WIDTH-1:0]  step;
        logic [PRIOR_LIMIT_WIDTH-1:0] prior;
    } t_limits;

    // History stage result handed to the decision stage
    typedef struct packed {
        logic                   valid;
        logic [SAT_WIDTH-1:0]   sat;
        logic                   pair;
        logic                   in_range;
        logic                   missing;
        t_epoch                 epoch;
        logic                   signs_differ;   // current and earlier step differ in sign
        logic [VALUE_WIDTH-1:0] cur_step;       // |now - newer|
        logic [VALUE_WIDTH-1:0] prev_step;      // |newer - older|
        logic                   jump_over;
        logic                   step_ok;
        logic                   prior_ok;
    } t_hist_res;

    // Address bits of one satellite index for a given satellite count
    function automatic int f_sat_aw(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gf_cycle_slip_detector.sv @@
// An accepted item passes the S1 registers, the S2 register and the result queue in turn.
// Throughput: one item per cycle unless the input stalls; set by the read-modify-write of
// the history memory and of the track counter memory, each with one-deep write forwarding.
// Reset (synchronous, active low): limits take reset values, then a clearing pass over
// all 2**(SAT_AW+1) history slots (256 at NUM_SATS=128) zeroes both memories; stall holds
// high during the pass while configuration writes are taken as usual.
`default_nettype none

module gf_cycle_slip_detector #(
    parameter int NUM_SATS = gfcs_pkg::NUM_SATS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    // Observation items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire gfcs_pkg::t_in_item                  i_in_item,

    // Result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output gfcs_pkg::t_out_item                      o_out_item,

    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [gfcs_pkg::CFG_ADDR_WIDTH-1:0] paddr,
    input  wire logic [gfcs_pkg::CFG_DATA_WIDTH-1:0] pwdata,
    output logic      [gfcs_pkg::CFG_DATA_WIDTH-1:0] prdata,
    output logic                                     pready
);

    localparam int SAT_AW = gfcs_pkg::f_sat_aw(NUM_SATS);
    localparam int SLOT_W = SAT_AW + 1;
    localparam int DEPTH  = gfcs_pkg::OUT_FIFO_DEPTH;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Pipeline:
    //   accept : history read issued at {pair, sat}
    //   S1     : history forwarded, written back as {newer, now}; step magnitudes
    //            and limit compares computed
    //   S2     : second difference, case code, track counter read-modify-write
    //   queue  : results wait here while the sink stalls
    // The pipeline never stalls. Instead the input is held off once as many items
    // are in flight as the result queue can hold, so every result finds a slot.

    gfcs_pkg::t_limits   limits;
    gfcs_pkg::t_hist_res hist_res;
    gfcs_pkg::t_out_item dec_item;
    logic                dec_valid;

    logic              r_clr_busy;
    logic [SLOT_W-1:0] r_clr_addr;
    logic [CNT_W-1:0]  r_outstanding;

    logic in_accept;
    logic out_accept;

    assign pready      = 1'b1;
    assign o_in_stall  = r_clr_busy || (r_outstanding == CNT_W'(DEPTH));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_accept  = o_out_valid && !i_out_stall;

    // Clearing pass over every history slot; the track memory is swept by the
    // low address bits within the same pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Items accepted and not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({in_accept, out_accept})
                2'b10:   r_outstanding <= r_outstanding + 1'b1;
                2'b01:   r_outstanding <= r_outstanding - 1'b1;
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    gfcs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_limits  (limits)
    );

    gfcs_hist #(
        .NUM_SATS (NUM_SATS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_in_item   (i_in_item),
        .i_clr_en    (r_clr_busy),
        .i_clr_addr  (r_clr_addr),
        .i_limits    (limits),
        .o_res       (hist_res)
    );

    gfcs_decide #(
        .NUM_SATS (NUM_SATS)
    ) u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (hist_res),
        .i_clr_en   (r_clr_busy),
        .i_clr_addr (r_clr_addr[SAT_AW-1:0]),
        .i_limits   (limits),
        .o_valid    (dec_valid),
        .o_item     (dec_item)
    );

    gfcs_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dec_valid),
        .i_item  (dec_item),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    a_outstanding_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= CNT_W'(DEPTH))
        else $error("more items in flight than queue slots");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_outstanding != '0))
        else $error("result offered with no item in flight");

    a_clear_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> (r_clr_addr == '0))
        else $error("clearing pass ended before covering every slot");

endmodule

`default_nettype wire

@@ rtl/core/gfcs_regs.sv @@
`default_nettype none

module gfcs_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_psel,
    input  wire logic                                i_penable,
    input  wire logic                                i_pwrite,
    input  wire logic [gfcs_pkg::CFG_ADDR_WIDTH-1:0] i_paddr,
    input  wire logic [gfcs_pkg::CFG_DATA_WIDTH-1:0] i_pwdata,
    output logic      [gfcs_pkg::CFG_DATA_WIDTH-1:0] o_prdata,
    output gfcs_pkg::t_limits                        o_limits
);

    gfcs_pkg::t_limits  r_limits;
    gfcs_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = gfcs_pkg::t_reg_idx'(i_paddr[3:2]);
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.jump  <= gfcs_pkg::JUMP_LIMIT_RESET;
            r_limits.diff  <= gfcs_pkg::DIFF_LIMIT_RESET;
            r_limits.step  <= gfcs_pkg::STEP_LIMIT_RESET;
            r_limits.prior <= gfcs_pkg::PRIOR_LIMIT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                gfcs_pkg::REG_JUMP_LIMIT: begin
                    r_limits.jump <= i_pwdata[gfcs_pkg::JUMP_LIMIT_WIDTH-1:0];
                end
                gfcs_pkg::REG_DIFF_LIMIT: begin
                    r_limits.diff <= i_pwdata[gfcs_pkg::DIFF_LIMIT_WIDTH-1:0];
                end
                gfcs_pkg::REG_STEP_LIMIT: begin
                    r_limits.step <= i_pwdata[gfcs_pkg::STEP_LIMIT_WIDTH-1:0];
                end
                gfcs_pkg::REG_PRIOR_LIMIT: begin
                    r_limits.prior <= i_pwdata[gfcs_pkg::PRIOR_LIMIT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gfcs_pkg::REG_JUMP_LIMIT:  o_prdata = gfcs_pkg::CFG_DATA_WIDTH'(r_limits.jump);
            gfcs_pkg::REG_DIFF_LIMIT:  o_prdata = gfcs_pkg::CFG_DATA_WIDTH'(r_limits.diff);
            gfcs_pkg::REG_STEP_LIMIT:  o_prdata = gfcs_pkg::CFG_DATA_WIDTH'(r_limits.step);
            gfcs_pkg::REG_PRIOR_LIMIT: o_prdata = gfcs_pkg::CFG_DATA_WIDTH'(r_limits.prior);
            default:                   o_prdata = '0;
        endcase
    end

    assign o_limits = r_limits;

endmodule

`default_nettype wire

@@ rtl/core/gfcs_hist.sv @@
`default_nettype none

// History stage: per-slot {older, newer} memory, read at accept,
// forwarded and rewritten in the following cycle, step magnitudes computed.
module gfcs_hist #(
    parameter int NUM_SATS = gfcs_pkg::NUM_SATS_DEFAULT
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_in_accept,
    input  wire gfcs_pkg::t_in_item                             i_in_item,
    input  wire logic                                           i_clr_en,
    input  wire logic [gfcs_pkg::f_sat_aw(NUM_SATS):0]          i_clr_addr,
    input  wire gfcs_pkg::t_limits                              i_limits,
    output gfcs_pkg::t_hist_res                                 o_res
);

    localparam int VW        = gfcs_pkg::VALUE_WIDTH;
    localparam int SAT_AW    = gfcs_pkg::f_sat_aw(NUM_SATS);
    localparam int SLOT_W    = SAT_AW + 1;
    localparam int DEPTH     = 2 ** SLOT_W;
    localparam int SAT_EXT_W = (SAT_AW > gfcs_pkg::SAT_WIDTH) ? SAT_AW : gfcs_pkg::SAT_WIDTH;

    // [2*VW-1:VW] older value, [VW-1:0] newer value
    logic [2*VW-1:0] r_mem [DEPTH];
    logic [2*VW-1:0] r_rd_data;

    logic              r_s1_valid;
    gfcs_pkg::t_in_item r_s1_item;

    logic              r_lw_valid;
    logic [SLOT_W-1:0] r_lw_addr;
    logic [2*VW-1:0]   r_lw_data;

    logic [SAT_EXT_W-1:0] in_sat_ext;
    logic [SAT_EXT_W-1:0] s1_sat_ext;
    logic [SLOT_W-1:0]    rd_slot;
    logic [SLOT_W-1:0]    s1_slot;

    logic [2*VW-1:0] hist;
    logic [VW-1:0]   pre1;
    logic [VW-1:0]   pre2;
    logic [VW-1:0]   now;
    logic [VW:0]     d_cur_p;
    logic [VW:0]     d_cur_n;
    logic [VW:0]     d_prev_p;
    logic [VW:0]     d_prev_n;
    logic            cur_neg;
    logic            prev_neg;
    logic [VW-1:0]   cur_step;
    logic [VW-1:0]   prev_step;
    logic            in_range;
    logic            missing;

    logic            wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [2*VW-1:0] wr_data;

    assign in_sat_ext = SAT_EXT_W'(i_in_item.sat_index);
    assign rd_slot    = {i_in_item.pair_select, in_sat_ext[SAT_AW-1:0]};
    assign s1_sat_ext = SAT_EXT_W'(r_s1_item.sat_index);
    assign s1_slot    = {r_s1_item.pair_select, s1_sat_ext[SAT_AW-1:0]};

    // The write at the edge of our read is not in the read data
    assign hist = (r_lw_valid && (r_lw_addr == s1_slot)) ? r_lw_data : r_rd_data;
    assign pre1 = hist[2*VW-1:VW];
    assign pre2 = hist[VW-1:0];
    assign now  = r_s1_item.gf_value;

    assign in_range = (32'(r_s1_item.sat_index) < 32'(NUM_SATS));
    assign missing  = (now == '0);

    assign d_cur_p  = {now[VW-1], now} - {pre2[VW-1], pre2};
    assign d_cur_n  = {pre2[VW-1], pre2} - {now[VW-1], now};
    assign d_prev_p = {pre2[VW-1], pre2} - {pre1[VW-1], pre1};
    assign d_prev_n = {pre1[VW-1], pre1} - {pre2[VW-1], pre2};

    assign cur_neg   = d_cur_p[VW];
    assign prev_neg  = d_prev_p[VW];
    assign cur_step  = cur_neg ? d_cur_n[VW-1:0] : d_cur_p[VW-1:0];
    assign prev_step = prev_neg ? d_prev_n[VW-1:0] : d_prev_p[VW-1:0];

    assign wr_en   = i_clr_en || (r_s1_valid && in_range && !missing);
    assign wr_addr = i_clr_en ? i_clr_addr : s1_slot;
    assign wr_data = i_clr_en ? '0 : {pre2, now};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_in_accept;
            r_lw_valid <= wr_en;
        end
        r_s1_item <= i_in_item;
        r_lw_addr <= wr_addr;
        r_lw_data <= wr_data;
    end

    always_comb begin
        o_res.valid        = r_s1_valid;
        o_res.sat          = r_s1_item.sat_index;
        o_res.pair         = r_s1_item.pair_select;
        o_res.in_range     = in_range;
        o_res.missing      = missing;
        if (pre1 == '0 && pre2 == '0) begin
            o_res.epoch = gfcs_pkg::EPOCH_FIRST;
        end else if (pre1 == '0) begin
            o_res.epoch = gfcs_pkg::EPOCH_SECOND;
        end else begin
            o_res.epoch = gfcs_pkg::EPOCH_LATER;
        end
        o_res.signs_differ = (cur_neg != prev_neg);
        o_res.cur_step     = cur_step;
        o_res.prev_step    = prev_step;
        o_res.jump_over    = (cur_step > VW'(i_limits.jump));
        o_res.step_ok      = (prev_step < VW'(i_limits.step));
        o_res.prior_ok     = (cur_step < VW'(i_limits.prior));
    end

    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_en |-> !r_s1_valid)
        else $error("history clear overlaps an item");

endmodule

`default_nettype wire

@@ rtl/core/gfcs_decide.sv @@
`default_nettype none

// Decision stage: second difference, case code, and the L1/L2 track
// counter read-modify-write with one-deep forwarding.
module gfcs_decide #(
    parameter int NUM_SATS = gfcs_pkg::NUM_SATS_DEFAULT
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire gfcs_pkg::t_hist_res                     i_res,
    input  wire logic                                    i_clr_en,
    input  wire logic [gfcs_pkg::f_sat_aw(NUM_SATS)-1:0] i_clr_addr,
    input  wire gfcs_pkg::t_limits                       i_limits,
    output logic                                         o_valid,
    output gfcs_pkg::t_out_item                          o_item
);

    localparam int VW        = gfcs_pkg::VALUE_WIDTH;
    localparam int TW        = gfcs_pkg::TRACK_WIDTH;
    localparam int SAT_AW    = gfcs_pkg::f_sat_aw(NUM_SATS);
    localparam int DEPTH     = 2 ** SAT_AW;
    localparam int SAT_EXT_W = (SAT_AW > gfcs_pkg::SAT_WIDTH) ? SAT_AW : gfcs_pkg::SAT_WIDTH;

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rd_data;

    gfcs_pkg::t_hist_res r_s2;

    logic              r_lw_valid;
    logic [SAT_AW-1:0] r_lw_addr;
    logic [TW-1:0]     r_lw_data;

    logic [SAT_EXT_W-1:0] in_sat_ext;
    logic [SAT_EXT_W-1:0] s2_sat_ext;
    logic [SAT_AW-1:0]    rd_addr;
    logic [SAT_AW-1:0]    s2_addr;

    logic [TW-1:0] trk_cur;
    logic [TW-1:0] trk_inc;
    logic [TW-1:0] trk_new;
    logic [VW:0]   d2_sum;
    logic [VW-1:0] d2_a;
    logic [VW-1:0] d2_b;
    logic [VW:0]   d2;
    logic          smooth;

    gfcs_pkg::t_case_code code;
    logic                 bump;
    logic                 trk_wr;

    logic              wr_en;
    logic [SAT_AW-1:0] wr_addr;
    logic [TW-1:0]     wr_data;

    assign in_sat_ext = SAT_EXT_W'(i_res.sat);
    assign rd_addr    = in_sat_ext[SAT_AW-1:0];
    assign s2_sat_ext = SAT_EXT_W'(r_s2.sat);
    assign s2_addr    = s2_sat_ext[SAT_AW-1:0];

    assign trk_cur = (r_lw_valid && (r_lw_addr == s2_addr)) ? r_lw_data : r_rd_data;
    assign trk_inc = (trk_cur == '1) ? trk_cur : trk_cur + 1'b1;

    // |(now - newer) - (newer - older)| from the two magnitudes
    assign d2_sum = {1'b0, r_s2.cur_step} + {1'b0, r_s2.prev_step};
    assign d2_a   = r_s2.cur_step - r_s2.prev_step;
    assign d2_b   = r_s2.prev_step - r_s2.cur_step;
    assign d2     = r_s2.signs_differ ? d2_sum
                  : {1'b0, (r_s2.cur_step >= r_s2.prev_step) ? d2_a : d2_b};
    assign smooth = (d2 < (VW + 1)'(i_limits.diff));

    always_comb begin
        code = gfcs_pkg::CASE_MISSING;
        bump = 1'b0;
        if (r_s2.in_range && !r_s2.missing) begin
            unique case (r_s2.epoch)
                gfcs_pkg::EPOCH_FIRST: begin
                    code = gfcs_pkg::CASE_FIRST;
                end
                gfcs_pkg::EPOCH_SECOND: begin
                    bump = 1'b1;
                    code = r_s2.jump_over ? gfcs_pkg::CASE_SECOND_SLIP
                                          : gfcs_pkg::CASE_SECOND_OK;
                end
                default: begin
                    if (smooth) begin
                        bump = r_s2.step_ok;
                        code = r_s2.step_ok ? gfcs_pkg::CASE_SMOOTH
                                            : gfcs_pkg::CASE_STEP_SLIP;
                    end else begin
                        bump = r_s2.prior_ok;
                        code = r_s2.prior_ok ? gfcs_pkg::CASE_PRIOR_SLIP
                                             : gfcs_pkg::CASE_CURRENT_SLIP;
                    end
                end
            endcase
        end
    end

    // Only L1/L2 observations move the counter
    assign trk_wr = r_s2.valid && r_s2.in_range && !r_s2.missing && !r_s2.pair;

    always_comb begin
        if (!r_s2.in_range) begin
            trk_new = '0;
        end else if (r_s2.missing || r_s2.pair) begin
            trk_new = trk_cur;
        end else if (code == gfcs_pkg::CASE_FIRST) begin
            trk_new = '0;
        end else if (bump) begin
            trk_new = trk_inc;
        end else begin
            trk_new = trk_cur;
        end
    end

    assign wr_en   = i_clr_en || trk_wr;
    assign wr_addr = i_clr_en ? i_clr_addr : s2_addr;
    assign wr_data = i_clr_en ? '0 : trk_new;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2       <= '0;
            r_lw_valid <= 1'b0;
        end else begin
            r_s2       <= i_res;
            r_lw_valid <= wr_en;
        end
        r_lw_addr <= wr_addr;
        r_lw_data <= wr_data;
    end

    assign o_valid = r_s2.valid;

    always_comb begin
        o_item.sat_echo    = r_s2.sat;
        o_item.pair_echo   = r_s2.pair;
        o_item.case_code   = code;
        o_item.slip        = (code == gfcs_pkg::CASE_SECOND_SLIP) ||
                             (code == gfcs_pkg::CASE_STEP_SLIP) ||
                             (code == gfcs_pkg::CASE_CURRENT_SLIP);
        o_item.track_count = trk_new;
    end

endmodule

`default_nettype wire

@@ rtl/core/gfcs_out_fifo.sv @@
`default_nettype none

module gfcs_out_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire gfcs_pkg::t_out_item i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output gfcs_pkg::t_out_item      o_item
);

    localparam int DEPTH = gfcs_pkg::OUT_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gfcs_pkg::t_out_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)) || pop)
        else $error("result queue overflow");

endmodule

`default_nettype wire

@@ tb/sv/gf_cycle_slip_detector_tb.sv @@
`default_nettype none

module gf_cycle_slip_detector_tb;

    localparam int CLK_HALF     = 6;        // 12 time unit period
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;        // margin for the pipe to empty
    localparam int CYCLE_LIMIT  = 200000;   // watchdog on the whole run
    localparam int POOL_SIZE    = 8;
    localparam int NUM_SATS     = gfcs_pkg::NUM_SATS_DEFAULT;
    localparam int NUM_SLOTS    = 2 * NUM_SATS;
    localparam int SAT_W        = gfcs_pkg::SAT_WIDTH;
    localparam int VAL_W        = gfcs_pkg::VALUE_WIDTH;
    localparam int DATA_W       = gfcs_pkg::CFG_DATA_WIDTH;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    gfcs_pkg::t_in_item                  i_in_item;
    logic                                o_out_valid;
    logic                                i_out_stall;
    gfcs_pkg::t_out_item                 o_out_item;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [gfcs_pkg::CFG_ADDR_WIDTH-1:0] paddr;
    logic [DATA_W-1:0]                   pwdata;
    logic [DATA_W-1:0]                   prdata;
    logic                                pready;

    gf_cycle_slip_detector uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the detector: per-slot history, L1/L2 track counters and
    // the four thresholds. Slot = {pair, sat}. A zero history value means
    // "nothing stored yet", same as in the block.
    // ------------------------------------------------------------------
    longint                           hist_older [NUM_SLOTS];
    longint                           hist_newer [NUM_SLOTS];
    logic [gfcs_pkg::TRACK_WIDTH-1:0] track_cnt  [NUM_SATS];
    longint                           lim_jump;
    longint                           lim_diff;
    longint                           lim_step;
    longint                           lim_prior;

    gfcs_pkg::t_out_item slip_reports_due[$];   // predicted results, oldest first

    int in_idle_pct;                    // chance per cycle that the sender holds off
    int out_stall_pct;                  // chance per cycle that the receiver stalls
    int sat_pool [POOL_SIZE];           // satellites most random items land on

    int          items_sent;
    int          results_checked;
    int          mismatches;
    int          case_hits [8];
    int unsigned cycle_cnt;

    // ------------------------------------------------------------------
    // Clock, cycle counter and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("%0t: timeout after %0d cycles, %0d results still due",
                 $time, cycle_cnt, slip_reports_due.size());
        $display("** gf_cycle_slip_detector: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // L1/L2 counter advance, saturating at all ones
    function automatic void count_epoch(input logic [SAT_W-1:0] sat, input logic l1l2);
        if (l1l2 && track_cnt[sat] != '1)
            track_cnt[sat] = track_cnt[sat] + 1'b1;
    endfunction

    // Works out the result of one accepted observation and updates the shadow.
    // With 128 satellites every 7-bit index is in range.
    // Values are at most 48 bits, so all differences below are exact in 64 bits.
    function automatic gfcs_pkg::t_out_item predict_slip(input gfcs_pkg::t_in_item obs);
        gfcs_pkg::t_out_item rpt;
        logic [7:0]          slot;
        logic                l1l2;
        longint              cur;
        longint              pre1;
        longint              pre2;
        longint              m_cur;
        longint              m_prev;
        longint              d2;
        rpt.sat_echo  = obs.sat_index;
        rpt.pair_echo = obs.pair_select;
        rpt.slip      = 1'b0;
        rpt.case_code = gfcs_pkg::CASE_MISSING;
        cur  = $signed(obs.gf_value);
        slot = {obs.pair_select, obs.sat_index};
        l1l2 = (obs.pair_select == 1'b0);
        if (cur != 0) begin
            pre1 = hist_older[slot];
            pre2 = hist_newer[slot];
            hist_older[slot] = pre2;
            hist_newer[slot] = cur;
            if (pre1 == 0 && pre2 == 0) begin
                rpt.case_code = gfcs_pkg::CASE_FIRST;
                if (l1l2)
                    track_cnt[obs.sat_index] = '0;
            end else if (pre1 == 0) begin
                count_epoch(obs.sat_index, l1l2);
                if (magnitude(pre2 - cur) > lim_jump) begin
                    rpt.case_code = gfcs_pkg::CASE_SECOND_SLIP;
                    rpt.slip      = 1'b1;
                end else begin
                    rpt.case_code = gfcs_pkg::CASE_SECOND_OK;
                end
            end else begin
                m_cur  = magnitude(cur - pre2);
                m_prev = magnitude(pre2 - pre1);
                d2     = magnitude((cur - pre2) - (pre2 - pre1));
                if (d2 < lim_diff) begin
                    if (m_prev < lim_step) begin
                        rpt.case_code = gfcs_pkg::CASE_SMOOTH;
                        count_epoch(obs.sat_index, l1l2);
                    end else begin
                        rpt.case_code = gfcs_pkg::CASE_STEP_SLIP;
                        rpt.slip      = 1'b1;
                    end
                end else begin
                    if (m_cur < lim_prior) begin
                        rpt.case_code = gfcs_pkg::CASE_PRIOR_SLIP;
                        count_epoch(obs.sat_index, l1l2);
                    end else begin
                        rpt.case_code = gfcs_pkg::CASE_CURRENT_SLIP;
                        rpt.slip      = 1'b1;
                    end
                end
            end
        end
        rpt.track_count = track_cnt[obs.sat_index];
        return rpt;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic gfcs_pkg::t_in_item mk_obs(input logic [SAT_W-1:0] sat,
                                                  input logic pair,
                                                  input logic [VAL_W-1:0] val);
        gfcs_pkg::t_in_item obs;
        obs.sat_index   = sat;
        obs.pair_select = pair;
        obs.gf_value    = val;
        return obs;
    endfunction

    // uniform in [-m, m]
    function automatic longint rnd_pm(input longint m);
        return longint'($urandom_range(32'(2 * m))) - m;
    endfunction

    // Next random observation. Mostly continues the arc already stored for
    // the chosen slot, with the offset scaled to whichever threshold the
    // next test compares against, so both sides of every limit get hit.
    function automatic gfcs_pkg::t_in_item next_obs();
        gfcs_pkg::t_in_item obs;
        logic [7:0]         slot;
        longint             pre1;
        longint             pre2;
        longint             base;
        longint             val;
        longint             scale;
        int unsigned        pick;
        if ($urandom_range(19) == 0)
            obs.sat_index = SAT_W'($urandom_range(NUM_SATS - 1));
        else
            obs.sat_index = SAT_W'(sat_pool[$urandom_range(POOL_SIZE - 1)]);
        obs.pair_select = 1'($urandom_range(1));
        slot = {obs.pair_select, obs.sat_index};
        pre1 = hist_older[slot];
        pre2 = hist_newer[slot];
        base = (pre1 == 0) ? pre2 : 2 * pre2 - pre1;   // linear extrapolation
        pick = $urandom_range(99);
        if (pick < 6) begin
            val = 0;                                   // missing
        end else if (pick < 11) begin
            val = $signed({$urandom, $urandom});       // anything at all
        end else if (pre2 == 0) begin
            val = longint'($signed($urandom)) <<< $urandom_range(15);
        end else if (pick < 60) begin
            // near-smooth continuation
            scale = (pre1 == 0) ? lim_jump : lim_diff;
            val = base + rnd_pm(scale + 1);
        end else if (pick < 75) begin
            // flat against the last value: rough arc excused by a prior slip
            val = pre2 + rnd_pm(lim_prior + 1);
        end else if (pick < 88) begin
            // big step; when extrapolated next time it tests the step limit
            val = pre2 + rnd_pm(2 * lim_step + 2);
        end else begin
            val = base + rnd_pm(longint'(1) << 20);
        end
        obs.gf_value = val[VAL_W-1:0];
        return obs;
    endfunction

    // ------------------------------------------------------------------
    // Observation sender. Returns right after the accepting edge with
    // valid still high; the next call (or wait_idle) decides at the next
    // falling edge whether valid stays up.
    // ------------------------------------------------------------------
    task automatic send_obs(input gfcs_pkg::t_in_item obs);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= obs;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        slip_reports_due.push_back(predict_slip(obs));
        items_sent++;
    endtask

    // Drop valid, wait for every due result, then let the pipe empty.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (slip_reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Configuration: APB write, then read back and compare
    // ------------------------------------------------------------------
    task automatic cfg_write(input gfcs_pkg::t_reg_idx idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            gfcs_pkg::REG_JUMP_LIMIT:
                lim_jump  = longint'(val[gfcs_pkg::JUMP_LIMIT_WIDTH-1:0]);
            gfcs_pkg::REG_DIFF_LIMIT:
                lim_diff  = longint'(val[gfcs_pkg::DIFF_LIMIT_WIDTH-1:0]);
            gfcs_pkg::REG_STEP_LIMIT:
                lim_step  = longint'(val[gfcs_pkg::STEP_LIMIT_WIDTH-1:0]);
            gfcs_pkg::REG_PRIOR_LIMIT:
                lim_prior = longint'(val[gfcs_pkg::PRIOR_LIMIT_WIDTH-1:0]);
            default: ;
        endcase
        // read back: new setup phase, psel stays up
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            gfcs_pkg::REG_JUMP_LIMIT: want = DATA_W'(lim_jump);
            gfcs_pkg::REG_DIFF_LIMIT: want = DATA_W'(lim_diff);
            gfcs_pkg::REG_STEP_LIMIT: want = DATA_W'(lim_step);
            default:                  want = DATA_W'(lim_prior);
        endcase
        if (rd !== want) begin
            mismatches++;
            $display("%0t: register %s read back, expected %0d, actual %0d",
                     $time, idx.name(), want, rd);
        end
    endtask

    task automatic set_limits(input int jump, input int diff, input int step, input int prior);
        wait_idle();
        cfg_write(gfcs_pkg::REG_JUMP_LIMIT, jump);
        cfg_write(gfcs_pkg::REG_DIFF_LIMIT, diff);
        cfg_write(gfcs_pkg::REG_STEP_LIMIT, step);
        cfg_write(gfcs_pkg::REG_PRIOR_LIMIT, prior);
    endtask

    task automatic run_arcs(input int n);
        foreach (sat_pool[i])
            sat_pool[i] = int'($urandom_range(NUM_SATS - 1));
        repeat (n) send_obs(next_obs());
    endtask

    // ------------------------------------------------------------------
    // Receiver stall and result checker
    // ------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        gfcs_pkg::t_out_item due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slip_reports_due.size() == 0) begin
                mismatches++;
                $display("%0t: nothing due: sat %0d pair %0d slip %0d code %0d trk %0d",
                         $time, o_out_item.sat_echo, o_out_item.pair_echo, o_out_item.slip,
                         o_out_item.case_code, o_out_item.track_count);
            end else begin
                due = slip_reports_due.pop_front();
                results_checked++;
                case_hits[o_out_item.case_code]++;
                if (due.sat_echo !== o_out_item.sat_echo || due.pair_echo !== o_out_item.pair_echo
                    || due.slip !== o_out_item.slip || due.case_code !== o_out_item.case_code
                    || due.track_count !== o_out_item.track_count) begin
                    mismatches++;
                    $display("%0t: mismatch exp sat %0d pair %0d slip %0d code %0d trk %0d",
                             $time, due.sat_echo, due.pair_echo, due.slip, due.case_code,
                             due.track_count);
                    $display("%0t:          got sat %0d pair %0d slip %0d code %0d trk %0d",
                             $time, o_out_item.sat_echo, o_out_item.pair_echo, o_out_item.slip,
                             o_out_item.case_code, o_out_item.track_count);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-picked epochs at reset limits (jump 200, diff 500, step 50000,
    // prior 250): every case code, each limit hit at or one off its boundary, the value
    // extremes and a pair-1 item reporting the pair-0 counter.
    task automatic test_directed();
        send_obs(mk_obs(7'd0, 1'b0, 48'sd0));        // missing on empty slot
        send_obs(mk_obs(7'd0, 1'b0, 48'sd1000));     // first
        send_obs(mk_obs(7'd0, 1'b0, 48'sd1200));     // jump equals limit: ok
        send_obs(mk_obs(7'd0, 1'b0, 48'sd1400));     // smooth
        send_obs(mk_obs(7'd0, 1'b0, 48'sd0));        // missing, counter reported
        send_obs(mk_obs(7'd0, 1'b0, 48'sd2099));     // second diff one below limit
        send_obs(mk_obs(7'd0, 1'b0, 48'sd3298));     // second diff equals limit: current slip
        send_obs(mk_obs(7'd0, 1'b1, 48'sd5));        // L1/L3 shows the L1/L2 counter
        send_obs(mk_obs(7'd1, 1'b0, 48'sd5));
        send_obs(mk_obs(7'd1, 1'b0, 48'sd206));      // jump one over limit
        send_obs(mk_obs(7'd1, 1'b0, 48'sd407));
        send_obs(mk_obs(7'd2, 1'b1, 48'sd10));
        send_obs(mk_obs(7'd2, 1'b1, 48'sd50010));
        send_obs(mk_obs(7'd2, 1'b1, 48'sd100010));   // earlier step equals step limit
        send_obs(mk_obs(7'd2, 1'b1, 48'sd100259));   // current step one below prior limit
        // full-scale swings: differences wider than the value itself
        send_obs(mk_obs(7'd3, 1'b0, 48'h7FFF_FFFF_FFFF));
        send_obs(mk_obs(7'd3, 1'b0, 48'h8000_0000_0000));
        send_obs(mk_obs(7'd3, 1'b0, 48'h7FFF_FFFF_FFFF));
        send_obs(mk_obs(7'd3, 1'b0, -48'sd1));
        send_obs(mk_obs(7'd3, 1'b0, 48'sd1));        // rough, but tiny current step
        send_obs(mk_obs(7'd127, 1'b1, -48'sd1));
        send_obs(mk_obs(7'd127, 1'b1, 48'sd0));
        send_obs(mk_obs(7'd127, 1'b0, 48'h8000_0000_0000));
    endtask

    // All limits at zero (nearly everything past the first epoch slips), then all
    // at large values (almost nothing does).
    task automatic test_limit_extremes();
        set_limits(0, 0, 0, 0);
        run_arcs(200);
        set_limits(1000000, 1000000, 10000000, 1000000);
        run_arcs(200);
    endtask

    // Small random limits so arcs straddle every threshold
    task automatic test_random_limits();
        repeat (2) begin
            set_limits($urandom_range(1000), $urandom_range(2000),
                       $urandom_range(200000), $urandom_range(1000));
            run_arcs(375);
        end
    endtask

    task automatic test_default_limits();
        set_limits(int'(gfcs_pkg::JUMP_LIMIT_RESET), int'(gfcs_pkg::DIFF_LIMIT_RESET),
                   int'(gfcs_pkg::STEP_LIMIT_RESET), int'(gfcs_pkg::PRIOR_LIMIT_RESET));
        run_arcs(750);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        items_sent      = 0;
        results_checked = 0;
        mismatches      = 0;
        foreach (case_hits[i]) case_hits[i] = 0;
        foreach (hist_older[i]) begin
            hist_older[i] = 0;
            hist_newer[i] = 0;
        end
        foreach (track_cnt[i]) track_cnt[i] = '0;
        lim_jump  = longint'(gfcs_pkg::JUMP_LIMIT_RESET);
        lim_diff  = longint'(gfcs_pkg::DIFF_LIMIT_RESET);
        lim_step  = longint'(gfcs_pkg::STEP_LIMIT_RESET);
        lim_prior = longint'(gfcs_pkg::PRIOR_LIMIT_RESET);

        // light sender gaps, heavy receiver stall
        in_idle_pct   = 36;
        out_stall_pct = 85;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the clearing pass holds stall high; send_obs waits it out

        test_directed();
        test_limit_extremes();

        // heavy sender gaps, light receiver stall
        wait_idle();
        in_idle_pct   = 85;
        out_stall_pct = 36;
        test_random_limits();

        // back to back, no stall
        wait_idle();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        test_default_limits();

        wait_idle();
        $display("Ran %0d observations (%0d results checked) under reset, zero, max and random",
                 items_sent, results_checked);
        $display("thresholds; hits per case code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 case_hits[0], case_hits[1], case_hits[2], case_hits[3],
                 case_hits[4], case_hits[5], case_hits[6], case_hits[7]);
        if (mismatches == 0 && slip_reports_due.size() == 0) begin
            $display("** gf_cycle_slip_detector: PASSED **");
        end else begin
            $display("** gf_cycle_slip_detector: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/gfcs_pkg.sv
rtl/core/gfcs_regs.sv
rtl/core/gfcs_hist.sv
rtl/core/gfcs_decide.sv
rtl/core/gfcs_out_fifo.sv
rtl/core/gf_cycle_slip_detector.sv
tb/sv/gf_cycle_slip_detector_tb.sv
